@@ hw/rtl/crclfc_pkg.sv @@
// ----------------------------------------------------------------------------
// crclfc_pkg
// Shared types, constants and helper functions of the CRC line frame checker.
// ----------------------------------------------------------------------------
package crclfc_pkg;

    localparam int BYTE_W = 8;
    localparam int CRC_W  = 16;
    localparam int LEN_W  = 7;
    localparam int HCNT_W = 3;

    localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_INIT   = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_TOP    = 16'h8000;
    localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'h2A;
    localparam logic [BYTE_W-1:0] NL_BYTE    = 8'h0A;
    localparam logic [HCNT_W-1:0] HEX_DIGITS = 3'd4;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CRC_W-1:0]  t_crc;

    // decoded hex digit
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // one result word
    typedef struct packed {
        logic             frame_good;
        logic             crc_present;
        logic [CRC_W-1:0] received_crc;
        logic [CRC_W-1:0] computed_crc;
        logic [LEN_W-1:0] line_length;
    } t_result;

    // ascii hex digit decode, upper and lower case
    function automatic t_hex hex_of(input t_byte c);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h61 + 8'd10);
        end
        return h;
    endfunction

    // space, tab, cr, vt, ff
    function automatic logic is_blank(input t_byte c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) ||
               (c == 8'h0B) || (c == 8'h0C);
    endfunction

endpackage

@@ hw/rtl/crclfc_if.sv @@
// ----------------------------------------------------------------------------
// crclfc_rx_if / crclfc_res_if
// Valid/ready channels of the CRC line frame checker: received bytes in,
// line results out.
// ----------------------------------------------------------------------------
interface crclfc_rx_if;
    logic                       valid;
    logic                       ready;
    logic [crclfc_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crclfc_res_if;
    logic                         valid;
    logic                         ready;
    logic                         frame_good;
    logic                         crc_present;
    logic [crclfc_pkg::CRC_W-1:0] received_crc;
    logic [crclfc_pkg::CRC_W-1:0] computed_crc;
    logic [crclfc_pkg::LEN_W-1:0] line_length;

    modport source (output valid, output frame_good, output crc_present,
                    output received_crc, output computed_crc, output line_length,
                    input ready);
    modport sink   (input valid, input frame_good, input crc_present,
                    input received_crc, input computed_crc, input line_length,
                    output ready);
endinterface

@@ hw/rtl/crc_line_frame_checker_unit.sv @@
// ----------------------------------------------------------------------------
// crc_line_frame_checker_unit
// Collects received bytes into newline-ended lines, runs a CRC-16 over the
// stored bytes, parses the hex trailer after the last '*' and reports one
// result word per non-empty line.
//
//   channel  | dir | word                              | handshake
//   ---------+-----+-----------------------------------+-------------
//   i_rx     | in  | rx_byte                           | valid/ready
//   o_res    | out | frame_good, crc_present,          | valid/ready
//            |     | received_crc, computed_crc,       |
//            |     | line_length                       |
//
// One byte per cycle sustained. A byte goes into an input register, the
// CRC byte update and the trailer parse run on the registered byte, and
// the result of a newline is written into the output register, which
// drives the result word. Input stalls only when a newline result meets a
// full output register that is not being drained. Reset is synchronous;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module crc_line_frame_checker_unit #(
    parameter int LINE_BYTES = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    crclfc_rx_if.sink    i_rx,
    crclfc_res_if.source o_res
);
    import crclfc_pkg::*;

    localparam int CNT_W = $clog2(LINE_BYTES);
    localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_BYTES - 1);

    // input register
    logic  r_in_valid;
    t_byte r_in_byte;

    // line state
    t_crc              r_run_crc,   n_run_crc;
    t_crc              r_star_crc,  n_star_crc;
    logic              r_star_seen, n_star_seen;
    t_crc              r_hex_val,   n_hex_val;
    logic [HCNT_W-1:0] r_hex_cnt,   n_hex_cnt;
    logic              r_hex_stop,  n_hex_stop;
    logic [CNT_W-1:0]  r_count,     n_count;

    // output register
    logic    r_out_valid;
    t_result r_out;
    t_result n_res;

    logic       is_nl;
    logic       emit;
    logic       advance;
    logic       proc;
    t_crc       crc_next;
    t_hex       hex_d;
    logic [EXT_W-1:0] len_ext;

    crclfc_crc_byte u_crc (
        .i_crc  (r_run_crc),
        .i_byte (r_in_byte),
        .o_crc  (crc_next)
    );

    // pipeline control
    assign is_nl      = (r_in_byte == NL_BYTE);
    assign emit       = r_in_valid && is_nl && (r_count != '0);
    assign advance    = !emit || !r_out_valid || o_res.ready;
    assign proc       = r_in_valid && advance;
    assign i_rx.ready = !r_in_valid || advance;

    // result of the line now closing
    assign len_ext = EXT_W'(r_count);
    always_comb begin
        n_res.crc_present  = r_star_seen;
        n_res.computed_crc = r_star_seen ? r_star_crc : r_run_crc;
        n_res.received_crc = r_star_seen ? r_hex_val : '0;
        n_res.frame_good   = !r_star_seen ||
                             ((r_hex_cnt != '0) && (r_hex_val == r_star_crc));
        n_res.line_length  = len_ext[LEN_W-1:0];
    end

    // line state update for one byte
    assign hex_d = hex_of(r_in_byte);
    always_comb begin
        n_run_crc   = r_run_crc;
        n_star_crc  = r_star_crc;
        n_star_seen = r_star_seen;
        n_hex_val   = r_hex_val;
        n_hex_cnt   = r_hex_cnt;
        n_hex_stop  = r_hex_stop;
        n_count     = r_count;
        if (proc) begin
            if (is_nl) begin
                n_run_crc   = CRC_INIT;
                n_star_crc  = '0;
                n_star_seen = 1'b0;
                n_hex_val   = '0;
                n_hex_cnt   = '0;
                n_hex_stop  = 1'b0;
                n_count     = '0;
            end else if (r_count < CNT_MAX) begin
                n_count   = r_count + 1'b1;
                n_run_crc = crc_next;
                if (r_in_byte == STAR_BYTE) begin
                    n_star_crc  = r_run_crc;
                    n_star_seen = 1'b1;
                    n_hex_val   = '0;
                    n_hex_cnt   = '0;
                    n_hex_stop  = 1'b0;
                end else if (r_star_seen && !r_hex_stop) begin
                    if (hex_d.ok) begin
                        n_hex_val = {r_hex_val[CRC_W-5:0], hex_d.val};
                        n_hex_cnt = r_hex_cnt + 1'b1;
                        if (n_hex_cnt >= HEX_DIGITS) begin
                            n_hex_stop = 1'b1;
                        end
                    end else if (!((r_hex_cnt == '0) && is_blank(r_in_byte))) begin
                        n_hex_stop = 1'b1;
                    end
                end
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_crc   <= CRC_INIT;
            r_star_crc  <= '0;
            r_star_seen <= 1'b0;
            r_hex_val   <= '0;
            r_hex_cnt   <= '0;
            r_hex_stop  <= 1'b0;
            r_count     <= '0;
        end else begin
            r_run_crc   <= n_run_crc;
            r_star_crc  <= n_star_crc;
            r_star_seen <= n_star_seen;
            r_hex_val   <= n_hex_val;
            r_hex_cnt   <= n_hex_cnt;
            r_hex_stop  <= n_hex_stop;
            r_count     <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_out <= n_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.frame_good   = r_out.frame_good;
    assign o_res.crc_present  = r_out.crc_present;
    assign o_res.received_crc = r_out.received_crc;
    assign o_res.computed_crc = r_out.computed_crc;
    assign o_res.line_length  = r_out.line_length;

endmodule

@@ hw/rtl/crclfc_crc_byte.sv @@
// ----------------------------------------------------------------------------
// crclfc_crc_byte
// Bytewise CRC-16 update, polynomial 0x1021, msb first, no reflection.
// ----------------------------------------------------------------------------
module crclfc_crc_byte (
    input  crclfc_pkg::t_crc  i_crc,
    input  crclfc_pkg::t_byte i_byte,
    output crclfc_pkg::t_crc  o_crc
);
    import crclfc_pkg::*;

    // eight shift steps of the bitwise crc
    always_comb begin
        t_crc c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int b = 0; b < BYTE_W; b++) begin
            if ((c & CRC_TOP) != '0) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

@@ hw/rtl/crclfc_checker.sv @@
// ----------------------------------------------------------------------------
// crclfc_checker
// Port-level checks of the CRC line frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module crclfc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic                         i_frame_good,
    input logic                         i_crc_present,
    input logic [crclfc_pkg::CRC_W-1:0] i_received_crc,
    input logic [crclfc_pkg::CRC_W-1:0] i_computed_crc,
    input logic [crclfc_pkg::LEN_W-1:0] i_line_length
);
    import crclfc_pkg::*;

    // stalled result word holds (all fields but crc_present)
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_frame_good) &&
        $stable(i_received_crc) && $stable(i_computed_crc) && $stable(i_line_length))
        else $error("result word changed while stalled");

    // empty lines never give a word
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_line_length != '0)
        else $error("result for an empty line");

    // a legacy line is always good and carries no received crc
    a_legacy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_crc_present |-> i_frame_good && (i_received_crc == '0))
        else $error("legacy line result inconsistent");

    // a good framed line has matching crc values
    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_crc_present && i_frame_good |->
        i_received_crc == i_computed_crc)
        else $error("good frame with crc mismatch");

endmodule

bind crc_line_frame_checker_unit crclfc_checker u_crclfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_frame_good   (o_res.frame_good),
    .i_crc_present  (o_res.crc_present),
    .i_received_crc (o_res.received_crc),
    .i_computed_crc (o_res.computed_crc),
    .i_line_length  (o_res.line_length)
);
